// File: design/pgb_pkg.sv
// Shared constants and types of the point grid max height binner.
package pgb_pkg;

    localparam int GRID_SIDE_DEF = 256;

    // Configuration register indexes
    localparam int          CFG_INDEX_W = 3;
    localparam logic [2:0]  CFG_MIN_X   = 3'd0;
    localparam logic [2:0]  CFG_MAX_Y   = 3'd1;
    localparam logic [2:0]  CFG_RECIP   = 3'd2;
    localparam logic [2:0]  CFG_WIDTH   = 3'd3;
    localparam logic [2:0]  CFG_HEIGHT  = 3'd4;

    localparam logic signed [31:0] RST_MIN_X  = 32'sd0;
    localparam logic signed [31:0] RST_MAX_Y  = 32'sd0;
    localparam logic [31:0]        RST_RECIP  = 32'd4294967;
    localparam logic [8:0]         RST_WIDTH  = 9'd256;
    localparam logic [8:0]         RST_HEIGHT = 9'd256;

    // Heights at or below -100000 m are stored but never reported
    localparam logic signed [31:0] FLOOR_MM = -32'sd100000000;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Stored word: valid flag above the 32-bit height
    localparam int WORD_W = 33;

    // Scaled coordinate of one axis, as it leaves the multiplier
    typedef struct packed {
        logic        neg;
        logic        floor_mode;
        logic [31:0] quot;
        logic        frac_nz;
    } axis_res_t;

endpackage

// File: design/pgb_axis_map.sv
// Two-stage scaling of one axis offset by the reciprocal cell size.
module pgb_axis_map (
    input  logic                     aclk,
    input  logic                     en,
    input  logic signed [32:0]       diff,
    input  logic                     floor_mode,
    input  logic [31:0]              recip,
    output pgb_pkg::axis_res_t       res
);
    import pgb_pkg::*;

    logic        neg_a_reg;
    logic        floor_a_reg;
    logic [31:0] mag_a_reg;
    logic        neg_b_reg;
    logic        floor_b_reg;
    logic [63:0] prod_b_reg;
    logic [32:0] diff_abs;

    // magnitude never exceeds 2^32 - 1, so it fits 32 bits
    assign diff_abs = diff[32] ? (33'd0 - diff) : diff;

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_a_reg   <= diff[32];
            floor_a_reg <= floor_mode;
            mag_a_reg   <= diff_abs[31:0];
            neg_b_reg   <= neg_a_reg;
            floor_b_reg <= floor_a_reg;
            prod_b_reg  <= 64'(mag_a_reg) * 64'(recip);
        end
    end

    always_comb begin
        res.neg        = neg_b_reg;
        res.floor_mode = floor_b_reg;
        res.quot       = prod_b_reg[63:32];
        res.frac_nz    = |prod_b_reg[31:0];
    end

endmodule

// File: design/pgb_cell_ram.sv
// Single-port-write, single-port-read cell memory with registered read data.
module pgb_cell_ram #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16,
    parameter int DW    = 33
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [DEPTH];

    // read returns the contents before a write at the same edge
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/point_grid_max_height_binner.sv
// A query result moves through stage registers s1 to s4 and then the output register to m_tvalid.
// Throughput: one word per cycle while the pipeline advances; the cell memory is read at the s3
// address and written at the s4 address; a write that lands at the edge of a later read is
// forwarded around the memory. The pipeline stalls only when a query result reaches a full
// output register while m_tready is low. Reset: synchronous active-low aresetn restores the
// registers and starts a clearing pass that zeroes every cell; s_tready stays low until it ends.
module point_grid_max_height_binner #(
    parameter int GRID_SIDE = pgb_pkg::GRID_SIDE_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pgb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    // input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,   // x_mm[31:0], y_mm[63:32], z_mm[95:64]
    input  logic                            s_tuser,   // action
    // result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // height_mm
    output logic                            m_tuser    // found
);
    import pgb_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(GRID_SIDE);

    // configuration
    logic signed [31:0] grid_min_x_reg;
    logic signed [31:0] grid_max_y_reg;
    logic [31:0]        cell_recip_reg;
    logic [8:0]         grid_width_reg;
    logic [8:0]         grid_height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_min_x_reg  <= RST_MIN_X;
            grid_max_y_reg  <= RST_MAX_Y;
            cell_recip_reg  <= RST_RECIP;
            grid_width_reg  <= RST_WIDTH;
            grid_height_reg <= RST_HEIGHT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MIN_X:  grid_min_x_reg  <= cfg_data;
                CFG_MAX_Y:  grid_max_y_reg  <= cfg_data;
                CFG_RECIP:  cell_recip_reg  <= cfg_data;
                CFG_WIDTH:  grid_width_reg  <= cfg_data[8:0];
                CFG_HEIGHT: grid_height_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // clearing pass
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_cnt_reg == AW'(CELLS - 1)) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
        end
    end

    // pipeline control
    logic adv;
    logic accept;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s1_query_reg, s2_query_reg, s3_query_reg, s4_query_reg;
    logic signed [31:0] s1_z_reg, s2_z_reg, s3_z_reg, s4_z_reg;
    logic          s3_inside_reg, s4_inside_reg;
    logic [AW-1:0] s3_addr_reg, s4_addr_reg;
    logic          m_valid_reg;

    // hold everything only while a query result has nowhere to go
    assign adv      = !(m_valid_reg && !m_tready && s4_valid_reg && s4_query_reg);
    assign s_tready = adv && !clearing_reg;
    assign accept   = s_tvalid && s_tready;

    // axis mapping
    logic signed [31:0] in_x, in_y;
    logic signed [32:0] diff_x, diff_y;
    axis_res_t          res_x, res_y;

    assign in_x   = s_tdata[31:0];
    assign in_y   = s_tdata[63:32];
    assign diff_x = 33'(in_x) - 33'(grid_min_x_reg);
    assign diff_y = 33'(grid_max_y_reg) - 33'(in_y);

    pgb_axis_map u_map_x (
        .aclk       (aclk),
        .en         (adv),
        .diff       (diff_x),
        .floor_mode (s_tuser),
        .recip      (cell_recip_reg),
        .res        (res_x)
    );

    pgb_axis_map u_map_y (
        .aclk       (aclk),
        .en         (adv),
        .diff       (diff_y),
        .floor_mode (s_tuser),
        .recip      (cell_recip_reg),
        .res        (res_y)
    );

    // range check and cell address
    logic [31:0]   lim_x, lim_y, coord_x, coord_y;
    logic          ok_x, ok_y;
    logic [AW-1:0] s2_addr;

    always_comb begin
        lim_x   = (32'(grid_width_reg) > 32'(GRID_SIDE))  ? 32'(GRID_SIDE) : 32'(grid_width_reg);
        lim_y   = (32'(grid_height_reg) > 32'(GRID_SIDE)) ? 32'(GRID_SIDE) : 32'(grid_height_reg);
        // a negative offset maps to zero only when it rounds there
        coord_x = res_x.neg ? 32'd0 : res_x.quot;
        coord_y = res_y.neg ? 32'd0 : res_y.quot;
        ok_x    = !(res_x.neg && ((res_x.quot != 32'd0) || (res_x.floor_mode && res_x.frac_nz)))
                  && (coord_x < lim_x);
        ok_y    = !(res_y.neg && ((res_y.quot != 32'd0) || (res_y.floor_mode && res_y.frac_nz)))
                  && (coord_y < lim_y);
        s2_addr = AW'(coord_y[CW-1:0]) * AW'(GRID_SIDE) + AW'(coord_x[CW-1:0]);
    end

    // memory and update
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] cur_word;
    logic              fwd_valid_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [WORD_W-1:0] fwd_word_reg;
    logic              cur_valid;
    logic signed [31:0] cur_height;
    logic              upd_wr;
    logic [WORD_W-1:0] upd_word;
    logic              ram_wr;
    logic [AW-1:0]     ram_wr_addr;
    logic [WORD_W-1:0] ram_wr_data;
    logic              found;

    always_comb begin
        // take the write that landed at the edge of this read
        cur_word   = (fwd_valid_reg && (fwd_addr_reg == s4_addr_reg)) ? fwd_word_reg : rd_word;
        cur_valid  = cur_word[WORD_W-1];
        cur_height = cur_word[31:0];
        upd_wr     = adv && s4_valid_reg && (s4_query_reg == ACT_INSERT) && s4_inside_reg
                     && (!cur_valid || (s4_z_reg > cur_height));
        upd_word   = {1'b1, s4_z_reg};
        found      = s4_inside_reg && cur_valid && (cur_height > FLOOR_MM);
        if (clearing_reg) begin
            ram_wr      = 1'b1;
            ram_wr_addr = clr_cnt_reg;
            ram_wr_data = '0;
        end else begin
            ram_wr      = upd_wr;
            ram_wr_addr = s4_addr_reg;
            ram_wr_data = upd_word;
        end
    end

    pgb_cell_ram #(
        .DEPTH (CELLS),
        .AW    (AW),
        .DW    (WORD_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (adv),
        .rd_addr (s3_addr_reg),
        .rd_data (rd_word),
        .wr_en   (ram_wr),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // stage registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            fwd_valid_reg <= upd_wr;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_query_reg  <= s_tuser;
            s1_z_reg      <= s_tdata[95:64];
            s2_query_reg  <= s1_query_reg;
            s2_z_reg      <= s1_z_reg;
            s3_query_reg  <= s2_query_reg;
            s3_z_reg      <= s2_z_reg;
            s3_inside_reg <= ok_x && ok_y;
            s3_addr_reg   <= s2_addr;
            s4_query_reg  <= s3_query_reg;
            s4_z_reg      <= s3_z_reg;
            s4_inside_reg <= s3_inside_reg;
            s4_addr_reg   <= s3_addr_reg;
            fwd_addr_reg  <= s4_addr_reg;
            fwd_word_reg  <= upd_word;
        end
    end

    // output register
    logic        m_found_reg;
    logic [31:0] m_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv && s4_valid_reg && (s4_query_reg == ACT_QUERY)) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s4_valid_reg && (s4_query_reg == ACT_QUERY)) begin
            m_found_reg  <= found;
            m_height_reg <= found ? cur_height : 32'd0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_height_reg;
    assign m_tuser  = m_found_reg;

    // checks
    a_no_accept_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s_tready)
        else $error("word accepted during clearing pass");

    a_query_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && s4_valid_reg && (s4_query_reg == ACT_QUERY)) |=> m_valid_reg)
        else $error("query left stage four without a result");

    a_found_above_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> ($signed(m_height_reg) > FLOOR_MM))
        else $error("reported height at or below floor");

    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_found_reg) |-> (m_height_reg == 32'd0))
        else $error("missing cell reports nonzero height");

    a_no_update_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing_reg |-> !s4_valid_reg)
        else $error("cell update in flight during clearing pass");

endmodule

// File: test/point_grid_max_height_binner_test.sv
// Self-checking testbench for the point grid max height binner.
module point_grid_max_height_binner_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pgb_pkg::*;

    localparam int GRID_CELLS  = GRID_SIDE_DEF * GRID_SIDE_DEF;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_SLACK = 8;
    localparam int LAYOUT_ITEMS = 135;
    localparam int EXTREME_ITEMS = 50;

    localparam logic signed [31:0] MM_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] MM_MAX = 32'sh7fff_ffff;

    typedef logic [CFG_INDEX_W-1:0] reg_index_t;

    typedef struct packed {
        logic               found;
        logic signed [31:0] height_mm;
    } answer_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index = '0;
    logic [31:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;    // x_mm[31:0], y_mm[63:32], z_mm[95:64]
    logic        s_tuser   = 1'b0;  // action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // height_mm
    logic        m_tuser;           // found

    // Grid image as the block should hold it
    logic signed [31:0] dsm_height [GRID_CELLS];
    bit                 dsm_written [GRID_CELLS];

    logic signed [31:0] cur_min_x  = RST_MIN_X;
    logic signed [31:0] cur_max_y  = RST_MAX_Y;
    logic [31:0]        cur_recip  = RST_RECIP;
    logic [8:0]         cur_width  = RST_WIDTH;
    logic [8:0]         cur_height = RST_HEIGHT;

    answer_t height_answers[$];

    int send_idle  = 0;
    int recv_stall = 0;
    int mismatches = 0;
    int cycles     = 0;

    point_grid_max_height_binner dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1ns aclk = 1'b1;
        #1ns aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
    end

    // Scale one axis difference into a cell coordinate; 0 if it falls off the grid.
    function automatic bit axis_cell(input longint diff, input bit floor_mode,
                                     input logic [8:0] limit, output int unsigned coord);
        bit                neg;
        longint unsigned   mag;
        longint unsigned   prod;
        longint unsigned   quot;
        longint unsigned   lim;
        neg  = diff < 0;
        mag  = neg ? longint'(-diff) : longint'(diff);
        prod = mag * longint'(cur_recip);
        quot = prod >> 32;
        lim  = (limit > GRID_SIDE_DEF) ? GRID_SIDE_DEF : limit;
        if (neg) begin
            // for inserts, truncation pulls a fraction past the edge back to zero
            if (quot != 0 || (floor_mode && prod[31:0] != 0))
                return 1'b0;
            quot = 0;
        end
        if (quot >= lim)
            return 1'b0;
        coord = int'(quot);
        return 1'b1;
    endfunction

    // Apply one accepted word to the grid image; queue the answer of a query.
    function automatic void rasterize_word(input logic act, input logic signed [31:0] x,
                                           input logic signed [31:0] y,
                                           input logic signed [31:0] z);
        int unsigned col;
        int unsigned row;
        int unsigned addr;
        bit          in_grid;
        answer_t     ans;
        col     = 0;
        row     = 0;
        in_grid = axis_cell(longint'(x) - longint'(cur_min_x), act == ACT_QUERY,
                            cur_width, col) &&
                  axis_cell(longint'(cur_max_y) - longint'(y), act == ACT_QUERY,
                            cur_height, row);
        addr = (row * GRID_SIDE_DEF + col) % GRID_CELLS;
        if (act == ACT_INSERT) begin
            if (in_grid && (!dsm_written[addr] || z > dsm_height[addr])) begin
                dsm_height[addr]  = z;
                dsm_written[addr] = 1'b1;
            end
        end else begin
            ans = '0;
            if (in_grid && dsm_written[addr] && dsm_height[addr] > FLOOR_MM) begin
                ans.found     = 1'b1;
                ans.height_mm = dsm_height[addr];
            end
            height_answers.push_back(ans);
        end
    endfunction

    always @(posedge aclk) begin
        answer_t ans;
        if (aresetn && m_tvalid && m_tready) begin
            if (height_answers.size() == 0) begin
                $error("result word with no query pending: found %0d height_mm %0d",
                       m_tuser, $signed(m_tdata));
                mismatches++;
            end else begin
                ans = height_answers.pop_front();
                if (m_tuser !== ans.found) begin
                    $error("found mismatch: expected %0d, got %0d", ans.found, m_tuser);
                    mismatches++;
                end
                if (m_tdata !== ans.height_mm) begin
                    $error("height_mm mismatch: expected %0d, got %0d",
                           ans.height_mm, $signed(m_tdata));
                    mismatches++;
                end
            end
        end
    end

    task automatic send_word(input logic act, input logic signed [31:0] x,
                             input logic signed [31:0] y, input logic signed [31:0] z);
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {z, y, x};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        rasterize_word(act, x, y, z);
    endtask

    // Hold off until every answer is back and the insert pipeline has emptied.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (height_answers.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        case (idx)
            CFG_MIN_X:  cur_min_x  = data;
            CFG_MAX_Y:  cur_max_y  = data;
            CFG_RECIP:  cur_recip  = data;
            CFG_WIDTH:  cur_width  = data[8:0];
            CFG_HEIGHT: cur_height = data[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_layout(input logic signed [31:0] min_x, input logic signed [31:0] max_y,
                                input logic [31:0] recip, input logic [8:0] width,
                                input logic [8:0] height);
        write_reg(CFG_MIN_X, min_x);
        write_reg(CFG_MAX_Y, max_y);
        write_reg(CFG_RECIP, recip);
        write_reg(CFG_WIDTH, {23'd0, width});
        write_reg(CFG_HEIGHT, {23'd0, height});
        // an unused index must leave the layout alone
        write_reg(reg_index_t'($urandom_range(CFG_HEIGHT + 1, (1 << CFG_INDEX_W) - 1)),
                  $urandom);
        cfg_valid <= 1'b0;
    endtask

    // Coordinate spread over the grid plus one cell on each side.
    function automatic logic signed [31:0] near_grid(input logic signed [31:0] origin,
                                                     input logic [8:0] cells,
                                                     input longint cell_mm,
                                                     input bit downward);
        longint unsigned span;
        longint unsigned rnd;
        longint          off;
        int unsigned     used;
        used = (cells > GRID_SIDE_DEF) ? GRID_SIDE_DEF : ((cells == 0) ? 1 : cells);
        span = longint'(used + 2) * cell_mm;
        rnd  = {$urandom, $urandom} >> 2;
        off  = longint'(rnd % span) - cell_mm;
        return downward ? 32'(longint'(origin) - off) : 32'(longint'(origin) + off);
    endfunction

    function automatic logic signed [31:0] rand_height();
        case ($urandom_range(9))
            0: return $urandom;
            1: return FLOOR_MM + 32'($urandom_range(2)) - 32'sd1;
            default: return 32'($urandom_range(2000000)) - 32'sd1000000;
        endcase
    endfunction

    task automatic rand_item(input longint cell_mm);
        logic               act;
        logic signed [31:0] x;
        logic signed [31:0] y;
        act = ($urandom_range(99) < 40) ? ACT_QUERY : ACT_INSERT;
        if ($urandom_range(99) < 10) begin
            x = $urandom;
            y = $urandom;
        end else begin
            x = near_grid(cur_min_x, cur_width, cell_mm, 1'b0);
            y = near_grid(cur_max_y, cur_height, cell_mm, 1'b1);
        end
        send_word(act, x, y, rand_height());
    endtask

    task automatic run_layouts(input int layouts);
        longint          cell_mm;
        longint unsigned recip;
        repeat (layouts) begin
            case ($urandom_range(4))
                0: cell_mm = 1;
                1: cell_mm = $urandom_range(2, 50);
                2: cell_mm = 1000;
                3: cell_mm = $urandom_range(1000, 100000);
                default: cell_mm = longint'(1) << $urandom_range(17, 31);
            endcase
            recip = (longint'(1) << 32) / cell_mm + $urandom_range(2) - 1;
            if (recip > 64'hFFFF_FFFF)
                recip = 64'hFFFF_FFFF;
            drain();
            apply_layout(32'($urandom_range(2000000000)) - 32'sd1000000000,
                         32'($urandom_range(2000000000)) - 32'sd1000000000,
                         recip[31:0],
                         ($urandom_range(99) < 20) ? 9'd256 : 9'($urandom_range(1, 16)),
                         ($urandom_range(99) < 20) ? 9'd256 : 9'($urandom_range(1, 16)));
            repeat (LAYOUT_ITEMS) rand_item(cell_mm);
        end
    endtask

    // Reset layout: cells of about one meter, origin at the top left corner.
    task automatic test_reset_layout();
        send_word(ACT_INSERT, 500, -500, 1234);
        send_word(ACT_QUERY, 500, -500, 0);
        send_word(ACT_INSERT, 500, -500, 1000);
        send_word(ACT_INSERT, 500, -500, 2000);
        send_word(ACT_QUERY, 500, -500, 0);
        // just west and north of the edge: an insert lands in cell zero, a query misses
        send_word(ACT_INSERT, -1, 1, 5000);
        send_word(ACT_QUERY, -1, 1, 0);
        send_word(ACT_QUERY, 0, 0, 0);
        send_word(ACT_INSERT, 255500, -255500, MM_MAX);
        send_word(ACT_QUERY, 255500, -255500, 0);
        send_word(ACT_INSERT, 256500, -1500, 42);
        send_word(ACT_QUERY, 256500, -1500, 0);
        send_word(ACT_INSERT, 10500, -20500, FLOOR_MM);
        send_word(ACT_QUERY, 10500, -20500, 0);
        send_word(ACT_INSERT, 10500, -20500, FLOOR_MM + 32'sd1);
        send_word(ACT_QUERY, 10500, -20500, 0);
        send_word(ACT_INSERT, 30500, -30500, MM_MIN);
        send_word(ACT_QUERY, 30500, -30500, MM_MAX);
        send_word(ACT_QUERY, 40500, -40500, 0);
        send_word(ACT_INSERT, MM_MAX, MM_MIN, 0);
        send_word(ACT_QUERY, MM_MIN, MM_MAX, -1);
        // back to back on one cell: the second update must see the first
        send_word(ACT_INSERT, 1500, -1500, 10);
        send_word(ACT_INSERT, 1500, -1500, 20);
        send_word(ACT_QUERY, 1500, -1500, 0);
    endtask

    task automatic test_layout_extremes();
        drain();
        apply_layout(MM_MIN, MM_MAX, 32'hFFFF_FFFF, 9'd511, 9'd511);
        repeat (EXTREME_ITEMS) rand_item(1);
        drain();
        apply_layout(MM_MAX, MM_MIN, 32'd1, 9'd256, 9'd256);
        repeat (EXTREME_ITEMS) rand_item(longint'(1) << 32);
        drain();
        // zero reciprocal folds everything into the corner cell
        apply_layout(32'sd0, 32'sd0, 32'd0, 9'd256, 9'd256);
        repeat (EXTREME_ITEMS) rand_item(1000);
        drain();
        apply_layout(-32'sd5000, 32'sd5000, RST_RECIP, 9'd0, 9'd5);
        repeat (EXTREME_ITEMS) rand_item(1000);
        drain();
        apply_layout(32'sd12345, -32'sd12345, RST_RECIP, 9'd1, 9'd1);
        repeat (EXTREME_ITEMS) rand_item(1000);
        drain();
        apply_layout(32'sd0, 32'sd0, 32'd1431655765, 9'd256, 9'd1);
        repeat (EXTREME_ITEMS) rand_item(3);
    endtask

    task automatic test_steady_stream();
        send_idle  = 0;
        recv_stall = 0;
        run_layouts(3);
    endtask

    task automatic test_sender_gaps();
        send_idle  = 75;
        recv_stall = 0;
        run_layouts(3);
    endtask

    task automatic test_receiver_stalls();
        send_idle  = 0;
        recv_stall = 75;
        run_layouts(3);
    endtask

    task automatic test_both_idle();
        send_idle  = 9;
        recv_stall = 9;
        run_layouts(3);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_layout();
        test_layout_extremes();
        test_steady_stream();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();
        drain();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
